[rtl/svsd_pkg.sv]
`timescale 1ns / 1ps

package svsd_pkg;

	localparam int NUM_DIGITS = 4;
	localparam int DIG_W      = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;
	localparam int VALUE_W    = 15;
	localparam int BCD_W      = 4;
	localparam int SEG_N      = 7;
	localparam int SEG_W      = 3;
	localparam int CATH_W     = 4;
	localparam int PADDR_W    = 2;
	localparam int PDATA_W    = 32;

	typedef enum logic {
		OP_TICK = 1'b0,
		OP_SET  = 1'b1
	} op_t;

	localparam logic [PADDR_W-1:0] ADDR_DISPLAY_ENABLE = PADDR_W'(0);

	typedef logic [NUM_DIGITS-1:0][BCD_W-1:0] digits_t;

	typedef struct packed {
		op_t                op;
		logic [VALUE_W-1:0] value;
	} svsd_in_t;

	typedef struct packed {
		logic [CATH_W-1:0] cathodes;
		logic [SEG_N-1:0]  anodes;
	} svsd_out_t;

	typedef struct packed {
		logic set;
		logic tick;
	} svsd_ctrl_t;

	function automatic logic [SEG_N-1:0] seg_pattern(input logic [BCD_W-1:0] d);
		logic [SEG_N-1:0] p;
		unique case (d)
			4'd0:    p = 7'b0111111;
			4'd1:    p = 7'b0000110;
			4'd2:    p = 7'b1011011;
			4'd3:    p = 7'b1001111;
			4'd4:    p = 7'b1100110;
			4'd5:    p = 7'b1101101;
			4'd6:    p = 7'b1111101;
			4'd7:    p = 7'b0000111;
			4'd8:    p = 7'b1111111;
			4'd9:    p = 7'b1101111;
			default: p = '0;
		endcase
		return p;
	endfunction

	// floor(v / 10^k) by reciprocal multiply, exact over the full input range
	function automatic logic [VALUE_W-1:0] div_pow10(input logic [VALUE_W-1:0] v, input int k);
		logic [31:0] p;
		logic [VALUE_W-1:0] q;
		p = '0;
		case (k)
			0: q = v;
			1: begin
				p = 32'(v) * 32'd52429;
				q = VALUE_W'(p >> 19);
			end
			2: begin
				p = 32'(v) * 32'd5243;
				q = VALUE_W'(p >> 19);
			end
			3: begin
				p = 32'(v) * 32'd33555;
				q = VALUE_W'(p >> 25);
			end
			4: begin
				p = 32'(v) * 32'd13422;
				q = VALUE_W'(p >> 27);
			end
			default: q = '0;
		endcase
		return q;
	endfunction

endpackage

[rtl/svsd_split.sv]
`timescale 1ns / 1ps

module svsd_split (
	input  logic [svsd_pkg::VALUE_W-1:0] value,
	output svsd_pkg::digits_t            digits
);

	logic [svsd_pkg::NUM_DIGITS:0][svsd_pkg::VALUE_W-1:0] quot;

	for (genvar k = 0; k <= svsd_pkg::NUM_DIGITS; k++) begin : g_quot
		assign quot[k] = svsd_pkg::div_pow10(value, k);
	end

	// digit k = q_k - 10 * q_(k+1)
	for (genvar k = 0; k < svsd_pkg::NUM_DIGITS; k++) begin : g_digit
		logic [svsd_pkg::VALUE_W-1:0] rem;
		assign rem = quot[k] - ((quot[k+1] << 3) + (quot[k+1] << 1));
		assign digits[k] = rem[svsd_pkg::BCD_W-1:0];
	end

endmodule

[rtl/svsd_scan.sv]
`timescale 1ns / 1ps

module svsd_scan (
	input  logic                 clk,
	input  logic                 arst_n,
	input  svsd_pkg::svsd_ctrl_t ctrl,
	input  svsd_pkg::digits_t    digits,
	output svsd_pkg::svsd_out_t  result
);

	svsd_pkg::digits_t              digit_store_q;
	logic [svsd_pkg::SEG_W-1:0]     segment_q;
	logic [svsd_pkg::DIG_W-1:0]     digit_q;
	logic [svsd_pkg::SEG_N-1:0]     pattern;
	logic [svsd_pkg::CATH_W-1:0]    cath;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			digit_store_q <= '0;
			segment_q     <= '0;
			digit_q       <= '0;
		end else begin
			if (ctrl.set) begin
				digit_store_q <= digits;
			end
			if (ctrl.tick) begin
				if (segment_q == svsd_pkg::SEG_W'(svsd_pkg::SEG_N - 1)) begin
					segment_q <= '0;
					if (digit_q == svsd_pkg::DIG_W'(svsd_pkg::NUM_DIGITS - 1)) begin
						digit_q <= '0;
					end else begin
						digit_q <= digit_q + 1'b1;
					end
				end else begin
					segment_q <= segment_q + 1'b1;
				end
			end
		end
	end

	always_comb begin
		pattern = svsd_pkg::seg_pattern(digit_store_q[digit_q]);
		for (int i = 0; i < svsd_pkg::CATH_W; i++) begin
			cath[i] = !(int'(digit_q) == i);
		end
		result.cathodes = cath;
		result.anodes   = pattern & (svsd_pkg::SEG_N'(1) << segment_q);
	end

endmodule

[rtl/seven_segment_scan_driver_core.sv]
`timescale 1ns / 1ps

// Four-digit common-cathode seven-segment scan driver, one segment lit per tick.
// A set beat stores the low decimal digits of value and returns nothing; a tick
// beat with display_enable set returns one beat (cathodes active low for the
// current digit, anodes holding that digit's bit for the current segment) and
// steps segment 0..6, then the digit. A tick while disabled returns nothing.
// One beat is taken every cycle unless a tick waits on a held output; a result
// passes through the input register, the digit split or segment decode, and the
// output register. display_enable sits at byte address 0 of the APB port.
module seven_segment_scan_driver_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  svsd_pkg::svsd_in_t            in_data,
	output logic                          out_valid,
	input  logic                          out_ready,
	output svsd_pkg::svsd_out_t           out_data,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [svsd_pkg::PADDR_W-1:0]  paddr,
	input  logic [svsd_pkg::PDATA_W-1:0]  pwdata,
	output logic [svsd_pkg::PDATA_W-1:0]  prdata,
	output logic                          pready
);

	logic                 enable_q;
	logic                 valid_s1;
	svsd_pkg::svsd_in_t   item_s1;
	logic                 out_valid_q;
	svsd_pkg::svsd_out_t  out_q;
	logic                 has_result;
	logic                 go;
	svsd_pkg::svsd_ctrl_t ctrl;
	svsd_pkg::digits_t    digits;
	svsd_pkg::svsd_out_t  result;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q <= 1'b0;
		end else if (psel && penable && pwrite && paddr == svsd_pkg::ADDR_DISPLAY_ENABLE) begin
			enable_q <= pwdata[0];
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr == svsd_pkg::ADDR_DISPLAY_ENABLE) begin
			prdata[0] = enable_q;
		end
	end

	assign has_result = valid_s1 && item_s1.op == svsd_pkg::OP_TICK && enable_q;
	assign go         = valid_s1 && (!has_result || !out_valid_q || out_ready);
	assign in_ready   = !valid_s1 || go;
	assign ctrl.set   = go && item_s1.op == svsd_pkg::OP_SET;
	assign ctrl.tick  = go && has_result;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= in_data;
		end
	end

	svsd_split u_split (
		.value  (item_s1.value),
		.digits (digits)
	);

	svsd_scan u_scan (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (ctrl),
		.digits (digits),
		.result (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctrl.tick) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.tick) begin
			out_q <= result;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule
